### sv/ikey_pkg.sv
// ----------------------------------------------------------------------------
// IDEA key schedule package
// Shared widths, constants, operation codes and the control/status bundles
// passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ikey_pkg;

  localparam int KeyW     = 128;
  localparam int WordW    = 16;
  localparam int IdxW     = 6;
  localparam int PosW     = 3;
  localparam int InDataW  = 128;
  localparam int InUserW  = 1;
  localparam int OutDataW = 24;
  localparam int StepW    = 4;

  localparam logic [IdxW-1:0]  LastIdx     = 6'd51;
  localparam logic [IdxW-1:0]  DecBase     = 6'd48;
  localparam logic [IdxW-1:0]  RoundStep   = 6'd6;
  localparam logic [PosW-1:0]  LastPos     = 3'd5;
  localparam logic [7:0]       RotStep     = 8'd25;
  localparam logic [StepW-1:0] LastInvStep = 4'd14;

  // what happens to a selected key word before it goes out
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_NEG  = 2'd1,
    OP_INV  = 2'd2
  } op_e;

  typedef struct packed {
    logic            load_key;
    logic            load_res_direct;
    logic            load_res_inv;
    logic            inv_start;
    logic            load_out;
    op_e             op;
    logic [IdxW-1:0] src_idx;
    logic [IdxW-1:0] out_idx;
    logic            out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic inv_done;
  } sts_t;

endpackage

### sv/ikey_inv.sv
// ----------------------------------------------------------------------------
// IDEA multiplicative inverse
// Computes x^65535 mod 65537 (0 stands for 65536) by 15 rounds of
// square-then-multiply, one modular product per cycle.
// ----------------------------------------------------------------------------
module ikey_inv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ikey_pkg::WordW-1:0] operand_i,
  output logic                       done_o,
  output logic [ikey_pkg::WordW-1:0] result_o
);

  logic [ikey_pkg::WordW-1:0]   x_q;
  logic [ikey_pkg::WordW-1:0]   acc_q, acc_d;
  logic [ikey_pkg::StepW-1:0]   step_q;
  logic                         sq_phase_q;
  logic                         busy_q;
  logic                         done_q;
  logic [ikey_pkg::WordW-1:0]   mul_b;
  logic [2*ikey_pkg::WordW-1:0] prod;
  logic [ikey_pkg::WordW-1:0]   prod_lo, prod_hi;

  assign mul_b   = sq_phase_q ? acc_q : x_q;
  assign prod    = acc_q * mul_b;
  assign prod_lo = prod[ikey_pkg::WordW-1:0];
  assign prod_hi = prod[2*ikey_pkg::WordW-1:ikey_pkg::WordW];

  // multiplication modulo 2^16+1, a zero operand meaning 2^16
  always_comb begin
    if (acc_q == '0) begin
      acc_d = 16'd1 - mul_b;
    end else if (mul_b == '0) begin
      acc_d = 16'd1 - acc_q;
    end else begin
      acc_d = (prod_lo - prod_hi) + {15'd0, (prod_lo < prod_hi)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      sq_phase_q <= 1'b1;
      step_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q     <= 1'b1;
        sq_phase_q <= 1'b1;
        step_q     <= '0;
      end else if (busy_q) begin
        sq_phase_q <= ~sq_phase_q;
        if (!sq_phase_q) begin
          if (step_q == ikey_pkg::LastInvStep) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= operand_i;
      acc_q <= operand_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

### sv/ikey_dp.sv
// ----------------------------------------------------------------------------
// IDEA key schedule datapath
// Holds the key, picks a rotated 16-bit key word, passes, negates or inverts it and
// drives the output register.
// ----------------------------------------------------------------------------
module ikey_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ikey_pkg::cmd_t                cmd_i,
  output ikey_pkg::sts_t                sts_o,
  input  logic [ikey_pkg::InDataW-1:0]  key_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ikey_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  logic [ikey_pkg::KeyW-1:0]     key_q;
  logic [2*ikey_pkg::KeyW-1:0]   key2;
  logic [2:0]                    blk, wrd;
  logic [7:0]                    blk_rot;
  logic [7:0]                    pos_sum;
  logic [6:0]                    pos;
  logic [7:0]                    top;
  logic [ikey_pkg::WordW-1:0]    word;
  logic [ikey_pkg::WordW-1:0]    inv_res;
  logic                          inv_done;
  logic [ikey_pkg::WordW-1:0]    res_q;
  logic                          out_valid_q;
  logic [ikey_pkg::OutDataW-1:0] out_data_q;
  logic                          out_last_q;
  logic                          out_free;

  // tdata is key_high in the low half, key_low in the high half
  assign key2 = {key_q, key_q};

  assign blk     = cmd_i.src_idx[5:3];
  assign wrd     = cmd_i.src_idx[2:0];
  assign blk_rot = {5'd0, blk} * ikey_pkg::RotStep;
  assign pos_sum = {1'b0, wrd, 4'd0} + blk_rot;
  assign pos     = pos_sum[6:0];
  assign top     = 8'd255 - {1'b0, pos};
  assign word    = key2[top -: ikey_pkg::WordW];

  ikey_inv u_inv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.inv_start),
    .operand_i (word),
    .done_o    (inv_done),
    .result_o  (inv_res)
  );

  assign out_free       = !out_valid_q || m_axis_tready_i;
  assign sts_o.out_free = out_free;
  assign sts_o.inv_done = inv_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= {key_i[ikey_pkg::KeyW/2-1:0], key_i[ikey_pkg::KeyW-1:ikey_pkg::KeyW/2]};
    end
    if (cmd_i.load_res_direct) begin
      res_q <= (cmd_i.op == ikey_pkg::OP_NEG) ? (16'd0 - word) : word;
    end else if (cmd_i.load_res_inv) begin
      res_q <= inv_res;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {2'd0, cmd_i.out_idx, res_q};
      out_last_q <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### sv/ikey_ctrl.sv
// ----------------------------------------------------------------------------
// IDEA key schedule sequencer
// Walks the 52 subkey positions and tells the datapath which key word to
// take and whether to pass, negate or invert it.
// ----------------------------------------------------------------------------
module ikey_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic           mode_i,
  output logic           s_ready_o,
  input  ikey_pkg::sts_t sts_i,
  output ikey_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEL  = 4'b0010,
    ST_INV  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [ikey_pkg::IdxW-1:0]   n_q;
  logic [ikey_pkg::PosW-1:0]   p_q;
  logic [ikey_pkg::IdxW-1:0]   base_q;
  logic                        mode_q;
  logic                        accept;
  logic                        swap;
  logic [ikey_pkg::IdxW-1:0]   dec_src;
  ikey_pkg::op_e               dec_op;
  ikey_pkg::op_e               op;

  assign accept    = (state_q == ST_IDLE) && s_valid_i;
  assign s_ready_o = (state_q == ST_IDLE);

  // first and last output rounds keep the additive keys unswapped
  assign swap = (base_q == ikey_pkg::DecBase) || (base_q == '0);

  // base_q tracks the encryption index of the round's first inverted key
  always_comb begin
    case (p_q)
      3'd0: begin
        dec_src = base_q;
        dec_op  = ikey_pkg::OP_INV;
      end
      3'd1: begin
        dec_src = base_q + (swap ? 6'd1 : 6'd2);
        dec_op  = ikey_pkg::OP_NEG;
      end
      3'd2: begin
        dec_src = base_q + (swap ? 6'd2 : 6'd1);
        dec_op  = ikey_pkg::OP_NEG;
      end
      3'd3: begin
        dec_src = base_q + 6'd3;
        dec_op  = ikey_pkg::OP_INV;
      end
      3'd4: begin
        dec_src = base_q - 6'd2;
        dec_op  = ikey_pkg::OP_PASS;
      end
      3'd5: begin
        dec_src = base_q - 6'd1;
        dec_op  = ikey_pkg::OP_PASS;
      end
      default: begin
        dec_src = base_q;
        dec_op  = ikey_pkg::OP_PASS;
      end
    endcase
  end

  assign op = mode_q ? dec_op : ikey_pkg::OP_PASS;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_valid_i) state_d = ST_SEL;
      ST_SEL:  state_d = (op == ikey_pkg::OP_INV) ? ST_INV : ST_PUSH;
      ST_INV:  if (sts_i.inv_done) state_d = ST_PUSH;
      ST_PUSH: begin
        if (sts_i.out_free) begin
          state_d = (n_q == ikey_pkg::LastIdx) ? ST_IDLE : ST_SEL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      p_q     <= '0;
      base_q  <= ikey_pkg::DecBase;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        n_q    <= '0;
        p_q    <= '0;
        base_q <= ikey_pkg::DecBase;
        mode_q <= mode_i;
      end else if ((state_q == ST_PUSH) && sts_i.out_free) begin
        n_q <= n_q + 6'd1;
        if (p_q == ikey_pkg::LastPos) begin
          p_q    <= '0;
          base_q <= base_q - ikey_pkg::RoundStep;
        end else begin
          p_q <= p_q + 3'd1;
        end
      end
    end
  end

  always_comb begin
    cmd_o.load_key        = accept;
    cmd_o.load_res_direct = (state_q == ST_SEL) && (op != ikey_pkg::OP_INV);
    cmd_o.inv_start       = (state_q == ST_SEL) && (op == ikey_pkg::OP_INV);
    cmd_o.load_res_inv    = (state_q == ST_INV) && sts_i.inv_done;
    cmd_o.load_out        = (state_q == ST_PUSH) && sts_i.out_free;
    cmd_o.op              = op;
    cmd_o.src_idx         = mode_q ? dec_src : n_q;
    cmd_o.out_idx         = n_q;
    cmd_o.out_last        = (n_q == ikey_pkg::LastIdx);
  end

endmodule

### sv/idea_key_schedule.sv
// After a key transfer the sequencer goes through ST_SEL (and ST_INV if the first subkey is an
// inverse) to ST_PUSH, which loads the output register and raises tvalid. A passed or negated
// subkey needs ST_SEL and ST_PUSH; an inverse also waits in ST_INV for the 30 sequential modular
// products of the shared inverse unit. One key in flight: tready is high only in ST_IDLE.
// Reset (rst_ni, async active low) idles the sequencer and empties the output
// register; no storage needs clearing.
// ----------------------------------------------------------------------------
// IDEA key schedule
// Expands a 128-bit key into the 52 encryption or decryption subkeys and
// streams them out in index order, the last one marked with tlast.
// ----------------------------------------------------------------------------
module idea_key_schedule (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ikey_pkg::InDataW-1:0]  s_axis_tdata_i,  // key_high[63:0], key_low[127:64]
  input  logic [ikey_pkg::InUserW-1:0]  s_axis_tuser_i,  // mode[0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ikey_pkg::OutDataW-1:0] m_axis_tdata_o,  // subkey[15:0], subkey_index[21:16]
  output logic                          m_axis_tlast_o   // last
);

  ikey_pkg::cmd_t cmd;
  ikey_pkg::sts_t sts;

  ikey_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .mode_i    (s_axis_tuser_i[0]),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ikey_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .key_i           (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### sim/idea_key_schedule_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IDEA key schedule testbench
// Streams 128-bit keys in both modes into the block and checks each subkey
// transfer (value, index and tlast) against a local schedule model. It runs
// directed corner keys, random keys under three sender/receiver idle mixes,
// and one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module idea_key_schedule_tb;

  localparam int NumSubkeys = 52;
  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 600;
  localparam int DrainCycles = 40;

  typedef struct {
    logic [ikey_pkg::WordW-1:0] subkey;
    logic [ikey_pkg::IdxW-1:0]  index;
    logic                       last;
  } subkey_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic [ikey_pkg::InDataW-1:0]  s_tdata = '0;
  logic [ikey_pkg::InUserW-1:0]  s_tuser = '0;
  logic                          m_tready = 1'b0;
  logic                          s_axis_tready_o;
  logic                          m_axis_tvalid_o;
  logic [ikey_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tlast_o;

  subkey_t subkey_q[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      tx_idle_pct = 13;
  int      rx_idle_pct = 48;
  bit      rx_hold = 1'b0;

  idea_key_schedule uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // key_high[63:0], key_low[127:64]
    .s_axis_tuser_i  (s_tuser),   // mode[0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // subkey[15:0], subkey_index[21:16]
    .m_axis_tlast_o  (m_axis_tlast_o)   // last
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // inverse modulo 65537, zero standing for 65536
  function automatic logic [ikey_pkg::WordW-1:0] mod_inverse(
      input logic [ikey_pkg::WordW-1:0] x);
    longint unsigned base;
    longint unsigned acc;
    int unsigned     e;
    base = (x == '0) ? 64'd65536 : 64'(x);
    acc = 1;
    e = 65535;
    while (e != 0) begin
      if (e[0]) acc = (acc * base) % 65537;
      base = (base * base) % 65537;
      e = e >> 1;
    end
    return acc[ikey_pkg::WordW-1:0];
  endfunction

  function automatic logic [ikey_pkg::WordW-1:0] add_inverse(
      input logic [ikey_pkg::WordW-1:0] x);
    return ikey_pkg::WordW'(17'h10000 - 17'(x));
  endfunction

  // build the 52 subkeys of one key and queue them as expected transfers
  function automatic void predict_schedule(input logic [63:0] key_high,
                                           input logic [63:0] key_low,
                                           input logic mode);
    logic [ikey_pkg::KeyW-1:0]  key;
    logic [ikey_pkg::KeyW-1:0]  rot;
    logic [ikey_pkg::WordW-1:0] enc[NumSubkeys];
    logic [ikey_pkg::WordW-1:0] dec[NumSubkeys];
    int                         sh;
    int                         d;
    int                         e;
    subkey_t                    item;
    key = {key_high, key_low};
    for (int n = 0; n < NumSubkeys; n++) begin
      sh = (25 * (n / 8)) % ikey_pkg::KeyW;
      rot = (sh == 0) ? key : ((key << sh) | (key >> (ikey_pkg::KeyW - sh)));
      enc[n] = rot[ikey_pkg::KeyW-1-16*(n%8) -: ikey_pkg::WordW];
    end
    dec[48] = mod_inverse(enc[0]);
    dec[49] = add_inverse(enc[1]);
    dec[50] = add_inverse(enc[2]);
    dec[51] = mod_inverse(enc[3]);
    for (int r = 0; r < 8; r++) begin
      d = 42 - 6 * r;
      e = 4 + 6 * r;
      dec[d+4] = enc[e];
      dec[d+5] = enc[e+1];
      dec[d]   = mod_inverse(enc[e+2]);
      // keep the additive pair unswapped in the first output round
      if (d != 0) begin
        dec[d+1] = add_inverse(enc[e+4]);
        dec[d+2] = add_inverse(enc[e+3]);
      end else begin
        dec[1] = add_inverse(enc[e+3]);
        dec[2] = add_inverse(enc[e+4]);
      end
      dec[d+3] = mod_inverse(enc[e+5]);
    end
    for (int n = 0; n < NumSubkeys; n++) begin
      item.subkey = mode ? dec[n] : enc[n];
      item.index  = ikey_pkg::IdxW'(n);
      item.last   = (ikey_pkg::IdxW'(n) == ikey_pkg::LastIdx);
      subkey_q.push_back(item);
    end
  endfunction

  // offer one key; tvalid stays high after the transfer until the next call
  task automatic send_key(input logic [63:0] key_high, input logic [63:0] key_low,
                          input logic mode);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {key_low, key_high};
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_schedule(key_high, key_low, mode);
  endtask

  function automatic logic [ikey_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h8000;
      default: return ikey_pkg::WordW'($urandom);
    endcase
  endfunction

  task automatic send_random_key();
    logic [ikey_pkg::KeyW-1:0] key;
    if ($urandom_range(0, 9) < 7) begin
      key = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      for (int w = 0; w < 8; w++) key[16*w +: 16] = pick_word();
    end
    send_key(key[127:64], key[63:0], 1'($urandom_range(0, 1)));
  endtask

  // corner keys in both modes: zero words hit the zero cases of both inverses
  task automatic test_directed_keys();
    logic [63:0] pattern[8];
    pattern = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA, 64'h0001_0001_0001_0001,
                64'h8000_8000_8000_8000, 64'hFFFF_0000_0001_8000,
                64'h0001_0002_0003_0004};
    for (int p = 0; p < 8; p++) begin
      send_key(pattern[p], (p == 7) ? 64'h0005_0006_0007_0008 : pattern[p], 1'b0);
      send_key(pattern[p], (p == 7) ? 64'h0005_0006_0007_0008 : pattern[p], 1'b1);
    end
    send_key(64'h8000_0000_0000_0000, 64'h0, 1'b1);
    send_key(64'h0, 64'h0000_0000_0000_0001, 1'b1);
    send_key(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1);
  endtask

  task automatic test_random_keys(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_random_key();
  endtask

  // stall the receiver for a long stretch while keys keep coming
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold = 1'b1;
    fork
      begin
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    repeat (8) send_random_key();
  endtask

  always @(posedge clk_i) begin
    if (rx_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    subkey_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (subkey_q.size() == 0) begin
        $error("unexpected subkey transfer: tdata %h tlast %b",
               m_axis_tdata_o, m_axis_tlast_o);
        mismatch_count++;
      end else begin
        want = subkey_q.pop_front();
        if (m_axis_tdata_o[15:0] !== want.subkey) begin
          $error("subkey: expected %h, actual %h", want.subkey, m_axis_tdata_o[15:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[21:16] !== want.index) begin
          $error("subkey_index: expected %0d, actual %0d", want.index,
                 m_axis_tdata_o[21:16]);
          mismatch_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %b, actual %b", want.last, m_axis_tlast_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_keys();
    test_random_keys(50, 13, 48);
    test_random_keys(50, 48, 13);
    test_output_backpressure();
    test_random_keys(32, 0, 0);
    s_tvalid <= 1'b0;
    wait (subkey_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && subkey_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
